FILE: hdl/rvmru_pkg.sv
// ----------------------------------------------------------------------------
// rvmru_pkg
// Shared constants and types for the recent vessel table.
// ----------------------------------------------------------------------------
package rvmru_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
   localparam int FILL_BITS   = $clog2(TABLE_DEPTH + 1);
   localparam int COUNT_BITS  = 16;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   // report types that carry position
   localparam logic [5:0] MSG_POS_FIRST = 6'd1;
   localparam logic [5:0] MSG_POS_LAST  = 6'd3;
   localparam logic [5:0] MSG_BASE      = 6'd4;
   localparam logic [5:0] MSG_BASE_RESP = 6'd21;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SEARCH = 5'b00010,
      ST_SHIFT  = 5'b00100,
      ST_RDCNT  = 5'b01000,
      ST_WRITE  = 5'b10000
   } state_type;

endpackage

FILE: hdl/recent_vessel_mru_table_core.sv
// ----------------------------------------------------------------------------
// recent_vessel_mru_table_core
// Most-recently-seen vessel table: move-to-front list with LRU eviction.
// ----------------------------------------------------------------------------
// One report at a time: busy is high from the start transfer until the
// result strobe. The scan reads one rank per cycle through the order and
// identity memories and stops at the matching rank r, or at the last held
// rank on a miss, and reads nothing with an empty table. The order memory
// then shifts one entry per cycle, s entries in all, where s is the prior
// rank on a hit, the fill level on a miss that adds an entry and 63 on an
// eviction. The RDCNT and WRITE states then do the count read-modify-write.
// The result strobe comes in the next cycle, and busy drops in that same
// cycle. The result appears on rsp_ for one cycle with rsp_valid and must
// be taken then; the receiver cannot stall it. No clearing pass is needed
// after reset.
module recent_vessel_mru_table_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [29:0] req_station_id,
   input  logic [5:0]  req_message_type,
   input  logic [3:0]  req_nav_status,
   input  logic signed [26:0] req_latitude,
   input  logic signed [27:0] req_longitude,
   input  logic [31:0] req_arrival_time,
   output logic        rsp_valid,
   output logic        rsp_hit,
   output logic [5:0]  rsp_prior_rank,
   output logic [rvmru_pkg::COUNT_BITS-1:0] rsp_seen_count,
   output logic        rsp_evicted,
   output logic [29:0] rsp_evicted_id,
   output logic [6:0]  rsp_occupancy
);

   localparam int IB = rvmru_pkg::IDX_BITS;
   localparam int FB = rvmru_pkg::FILL_BITS;
   localparam int CB = rvmru_pkg::COUNT_BITS;

   // memories
   logic [IB-1:0]  order_mem  [rvmru_pkg::TABLE_DEPTH];
   logic [29:0]    id_mem     [rvmru_pkg::TABLE_DEPTH];
   logic [CB-1:0]  count_mem  [rvmru_pkg::TABLE_DEPTH];
   logic [3:0]     status_mem [rvmru_pkg::TABLE_DEPTH];
   logic [26:0]    lat_mem    [rvmru_pkg::TABLE_DEPTH];
   logic [27:0]    lon_mem    [rvmru_pkg::TABLE_DEPTH];
   logic [31:0]    time_mem   [rvmru_pkg::TABLE_DEPTH];

   rvmru_pkg::state_type state_ff, state_in;
   logic [FB-1:0]  fill_ff, fill_in;
   logic [FB-1:0]  issue_ff, issue_in;
   logic           v1_ff, v1_in, v2_ff, v2_in;
   logic [IB-1:0]  rank1_ff, rank2_ff, slot2_ff;
   logic [IB-1:0]  ord_q_ff, id_raddr;
   logic [29:0]    id_q_ff;
   logic [CB-1:0]  cnt_q_ff;
   logic [IB-1:0]  order_raddr;

   // latched report
   logic [29:0] key_ff;
   logic [5:0]  type_ff;
   logic [3:0]  nav_ff;
   logic [26:0] lat_ff;
   logic [27:0] lon_ff;
   logic [31:0] when_ff;

   // outcome of the scan
   logic          hit_ff, hit_in, evict_ff, evict_in;
   logic [IB-1:0] slot_ff, slot_in, rank_ff, rank_in;
   logic [29:0]   evid_ff, evid_in;
   logic [IB-1:0] shift_ff, shift_in, pend_addr_ff, pend_addr_in;
   logic          pend_ff, pend_in;

   // response registers
   logic          rsp_valid_ff;
   logic          rsp_hit_ff, rsp_evicted_ff;
   logic [5:0]    rsp_rank_ff;
   logic [CB-1:0] rsp_count_ff;
   logic [29:0]   rsp_evid_ff;
   logic [6:0]    rsp_occ_ff;

   logic          match, last, decide;
   logic          upd_stat, upd_pos;
   logic          order_we, order_front;
   logic [IB-1:0] order_waddr, order_wdata;
   logic [CB-1:0] new_count;

   assign busy     = (state_ff != rvmru_pkg::ST_IDLE);
   assign match    = (id_q_ff == key_ff);
   assign last     = ({1'b0, rank2_ff} == fill_ff - FB'(1));
   assign decide   = v2_ff && (match || last);
   assign id_raddr = ord_q_ff;

   assign upd_stat = (type_ff >= rvmru_pkg::MSG_POS_FIRST) &&
                     (type_ff <= rvmru_pkg::MSG_POS_LAST);
   assign upd_pos  = upd_stat || (type_ff == rvmru_pkg::MSG_BASE) ||
                     (type_ff == rvmru_pkg::MSG_BASE_RESP);

   assign new_count = !hit_ff ? CB'(1) :
                      (cnt_q_ff == rvmru_pkg::COUNT_MAX) ? cnt_q_ff : cnt_q_ff + CB'(1);

   // order memory addressing: scan reads by rank, shift reads one rank up
   assign order_raddr = (state_ff == rvmru_pkg::ST_SEARCH) ? issue_ff[IB-1:0]
                                                           : shift_ff - IB'(1);
   assign order_front = (state_ff == rvmru_pkg::ST_SHIFT) && (shift_ff == '0) && !pend_ff;
   assign order_we    = (state_ff == rvmru_pkg::ST_SHIFT) && (pend_ff || order_front);
   assign order_waddr = pend_ff ? pend_addr_ff : '0;
   assign order_wdata = pend_ff ? ord_q_ff : slot_ff;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      issue_in     = issue_ff;
      v1_in        = 1'b0;
      v2_in        = v1_ff;
      hit_in       = hit_ff;
      evict_in     = evict_ff;
      slot_in      = slot_ff;
      rank_in      = rank_ff;
      evid_in      = evid_ff;
      shift_in     = shift_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      unique case (state_ff)
         rvmru_pkg::ST_IDLE: begin
            v2_in = 1'b0;
            if (start) begin
               state_in = rvmru_pkg::ST_SEARCH;
               issue_in = '0;
            end
         end
         rvmru_pkg::ST_SEARCH: begin
            if (issue_ff < fill_ff) begin
               v1_in    = 1'b1;
               issue_in = issue_ff + FB'(1);
            end
            if (fill_ff == '0 || decide) begin
               state_in = rvmru_pkg::ST_SHIFT;
               v1_in    = 1'b0;
               v2_in    = 1'b0;
               evict_in = 1'b0;
               evid_in  = '0;
               if (fill_ff != '0 && match) begin
                  hit_in   = 1'b1;
                  slot_in  = slot2_ff;
                  rank_in  = rank2_ff;
                  shift_in = rank2_ff;
               end else if (fill_ff == FB'(rvmru_pkg::TABLE_DEPTH)) begin
                  hit_in   = 1'b0;
                  slot_in  = slot2_ff;
                  rank_in  = '0;
                  shift_in = IB'(rvmru_pkg::TABLE_DEPTH - 1);
                  evict_in = 1'b1;
                  evid_in  = id_q_ff;
               end else begin
                  hit_in   = 1'b0;
                  slot_in  = fill_ff[IB-1:0];
                  rank_in  = '0;
                  shift_in = fill_ff[IB-1:0];
                  fill_in  = fill_ff + FB'(1);
               end
            end
         end
         rvmru_pkg::ST_SHIFT: begin
            if (shift_ff != '0) begin
               pend_in      = 1'b1;
               pend_addr_in = shift_ff;
               shift_in     = shift_ff - IB'(1);
            end else if (!pend_ff) begin
               state_in = rvmru_pkg::ST_RDCNT;
            end
         end
         rvmru_pkg::ST_RDCNT: state_in = rvmru_pkg::ST_WRITE;
         rvmru_pkg::ST_WRITE: state_in = rvmru_pkg::ST_IDLE;
         default:             state_in = rvmru_pkg::ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rvmru_pkg::ST_IDLE;
         fill_ff      <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= (state_ff == rvmru_pkg::ST_WRITE);
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      issue_ff     <= issue_in;
      rank1_ff     <= issue_ff[IB-1:0];
      rank2_ff     <= rank1_ff;
      slot2_ff     <= ord_q_ff;
      hit_ff       <= hit_in;
      evict_ff     <= evict_in;
      slot_ff      <= slot_in;
      rank_ff      <= rank_in;
      evid_ff      <= evid_in;
      shift_ff     <= shift_in;
      pend_addr_ff <= pend_addr_in;
      if (state_ff == rvmru_pkg::ST_IDLE && start) begin
         key_ff  <= req_station_id;
         type_ff <= req_message_type;
         nav_ff  <= req_nav_status;
         lat_ff  <= req_latitude;
         lon_ff  <= req_longitude;
         when_ff <= req_arrival_time;
      end
      if (state_ff == rvmru_pkg::ST_WRITE) begin
         rsp_hit_ff     <= hit_ff;
         rsp_rank_ff    <= 6'(rank_ff);
         rsp_count_ff   <= new_count;
         rsp_evicted_ff <= evict_ff;
         rsp_evid_ff    <= evid_ff;
         rsp_occ_ff     <= 7'(fill_ff);
      end
   end

   // order memory: one read, one write per cycle
   always_ff @(posedge clock) begin
      ord_q_ff <= order_mem[order_raddr];
      if (order_we) begin
         order_mem[order_waddr] <= order_wdata;
      end
   end

   // identity memory
   always_ff @(posedge clock) begin
      id_q_ff <= id_mem[id_raddr];
      if (state_ff == rvmru_pkg::ST_WRITE && !hit_ff) begin
         id_mem[slot_ff] <= key_ff;
      end
   end

   // count memory read-modify-write
   always_ff @(posedge clock) begin
      cnt_q_ff <= count_mem[slot_ff];
      if (state_ff == rvmru_pkg::ST_WRITE) begin
         count_mem[slot_ff] <= new_count;
      end
   end

   // report payload stores; a new entry without position gets zeros
   always_ff @(posedge clock) begin
      if (state_ff == rvmru_pkg::ST_WRITE) begin
         if (upd_stat || !hit_ff) begin
            status_mem[slot_ff] <= upd_stat ? nav_ff : 4'd0;
         end
         if (upd_pos || !hit_ff) begin
            lat_mem[slot_ff]  <= upd_pos ? lat_ff : 27'd0;
            lon_mem[slot_ff]  <= upd_pos ? lon_ff : 28'd0;
            time_mem[slot_ff] <= upd_pos ? when_ff : 32'd0;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_prior_rank = rsp_rank_ff;
   assign rsp_seen_count = rsp_count_ff;
   assign rsp_evicted    = rsp_evicted_ff;
   assign rsp_evicted_id = rsp_evid_ff;
   assign rsp_occupancy  = rsp_occ_ff;

endmodule

FILE: bench/recent_vessel_mru_table_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// recent_vessel_mru_table_core_test
// Self-checking bench for the recent vessel table. A behavioral copy of the
// move-to-front list predicts every result; directed tests cover hits,
// misses, eviction and report types, then random reports over small and
// large identity pools run with random gaps.
// ----------------------------------------------------------------------------
module recent_vessel_mru_table_core_test;

   localparam int CYCLE_LIMIT = 2000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [29:0] req_station_id = '0;
   logic [5:0]  req_message_type = '0;
   logic [3:0]  req_nav_status = '0;
   logic signed [26:0] req_latitude = '0;
   logic signed [27:0] req_longitude = '0;
   logic [31:0] req_arrival_time = '0;
   logic        rsp_valid;
   logic        rsp_hit;
   logic [5:0]  rsp_prior_rank;
   logic [rvmru_pkg::COUNT_BITS-1:0] rsp_seen_count;
   logic        rsp_evicted;
   logic [29:0] rsp_evicted_id;
   logic [6:0]  rsp_occupancy;

   typedef struct packed {
      logic        hit;
      logic [5:0]  prior_rank;
      logic [rvmru_pkg::COUNT_BITS-1:0] seen_count;
      logic        evicted;
      logic [29:0] evicted_id;
      logic [6:0]  occupancy;
   } table_result_type;

   recent_vessel_mru_table_core dut (.*);

   always #6 clock = ~clock;

   // predictor state
   logic [29:0]                      vessel_id   [rvmru_pkg::TABLE_DEPTH];
   logic [rvmru_pkg::COUNT_BITS-1:0] vessel_count[rvmru_pkg::TABLE_DEPTH];
   logic [rvmru_pkg::IDX_BITS-1:0]   rank_slot   [rvmru_pkg::TABLE_DEPTH];
   int                               held;

   table_result_type pending_results[$];
   int errors = 0;
   int reports = 0;
   int hits_seen = 0;
   int evictions_seen = 0;
   longint cycles = 0;

   // predict one report's result and update the table copy
   function automatic table_result_type predict_report(logic [29:0] id);
      table_result_type res;
      int rank;
      int slot;
      rank = -1;
      slot = 0;
      res = '0;
      for (int r = 0; r < held; r++)
         if (rank < 0 && vessel_id[rank_slot[r]] == id) begin
            rank = r;
            slot = rank_slot[r];
         end
      if (rank >= 0) begin
         res.hit = 1'b1;
         res.prior_rank = rank[5:0];
         for (int r = rank; r > 0; r--) rank_slot[r] = rank_slot[r-1];
      end else begin
         if (held < rvmru_pkg::TABLE_DEPTH) begin
            slot = held;
            for (int r = held; r > 0; r--) rank_slot[r] = rank_slot[r-1];
            held++;
         end else begin
            slot = rank_slot[rvmru_pkg::TABLE_DEPTH-1];
            res.evicted = 1'b1;
            res.evicted_id = vessel_id[slot];
            for (int r = rvmru_pkg::TABLE_DEPTH-1; r > 0; r--) rank_slot[r] = rank_slot[r-1];
         end
         vessel_id[slot] = id;
         vessel_count[slot] = '0;
      end
      rank_slot[0] = slot[rvmru_pkg::IDX_BITS-1:0];
      if (vessel_count[slot] != rvmru_pkg::COUNT_MAX) vessel_count[slot]++;
      res.seen_count = vessel_count[slot];
      res.occupancy = held[6:0];
      return res;
   endfunction

   // cycle counter and timeout
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // result checker
   always @(posedge clock) begin
      table_result_type want;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $error("result with nothing expected");
            errors++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_hit !== want.hit) begin
               $error("hit exp %0h got %0h", want.hit, rsp_hit); errors++;
            end
            if (rsp_prior_rank !== want.prior_rank) begin
               $error("prior_rank exp %0d got %0d", want.prior_rank, rsp_prior_rank);
               errors++;
            end
            if (rsp_seen_count !== want.seen_count) begin
               $error("seen_count exp %0d got %0d", want.seen_count, rsp_seen_count);
               errors++;
            end
            if (rsp_evicted !== want.evicted) begin
               $error("evicted exp %0h got %0h", want.evicted, rsp_evicted); errors++;
            end
            if (rsp_evicted_id !== want.evicted_id) begin
               $error("evicted_id exp %0h got %0h", want.evicted_id, rsp_evicted_id);
               errors++;
            end
            if (rsp_occupancy !== want.occupancy) begin
               $error("occupancy exp %0d got %0d", want.occupancy, rsp_occupancy);
               errors++;
            end
         end
      end
   end

   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200) : $urandom_range(0, 3);
      repeat (n) @(posedge clock);
   endtask

   // send one report; the transfer happens at the edge where busy is low
   task automatic send_report(logic [29:0] id, logic [5:0] mtype, logic [3:0] nav,
                              logic [26:0] lat, logic [27:0] lon, logic [31:0] when,
                              bit gaps);
      table_result_type res;
      if (gaps) idle_gap();
      req_station_id   <= id;
      req_message_type <= mtype;
      req_nav_status   <= nav;
      req_latitude     <= lat;
      req_longitude    <= lon;
      req_arrival_time <= when;
      start            <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      res = predict_report(id);
      if (res.hit) hits_seen++;
      if (res.evicted) evictions_seen++;
      pending_results.push_back(res);
      reports++;
      start <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_random(logic [29:0] id, bit gaps);
      send_report(id, 6'($urandom), 4'($urandom), 27'($urandom), 28'($urandom),
                  $urandom, gaps);
   endtask

   task automatic drain();
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // extremes of every field and each report type that carries position
   task automatic test_field_extremes();
      send_report(30'h0, 6'd0, 4'h0, 27'h0, 28'h0, 32'h0, 0);
      send_report(30'h3FFFFFFF, 6'd63, 4'hF, 27'h3FFFFFF, 28'h7FFFFFF, 32'hFFFFFFFF, 0);
      send_report(30'h3FFFFFFF, rvmru_pkg::MSG_POS_FIRST, 4'hF, 27'h4000000, 28'h8000000,
                  32'h1, 0);
      send_report(30'h0, rvmru_pkg::MSG_POS_LAST, 4'h5, 27'h7FFFFFF, 28'hFFFFFFF, 32'h2, 0);
      send_report(30'h1, 6'd2, 4'hA, 27'h1234567, 28'h89ABCDE, 32'h3, 0);
      send_report(30'h2, rvmru_pkg::MSG_BASE, 4'h3, 27'h0, 28'h0, 32'h4, 0);
      send_report(30'h1, rvmru_pkg::MSG_BASE_RESP, 4'h3, 27'h1, 28'h1, 32'h5, 0);
      send_report(30'h3FFFFFFF, 6'd5, 4'h0, 27'h0, 28'h0, 32'h6, 0);
      send_report(30'h2, 6'd20, 4'h0, 27'h0, 28'h0, 32'h7, 0);
      drain();
   endtask

   // fill the table past its depth so misses evict the least recent entries, then hit the last
   task automatic test_fill_and_evict();
      for (int i = 0; i < rvmru_pkg::TABLE_DEPTH + 6; i++)
         send_random(30'(30'h100 + i), 0);
      send_random(30'(30'h100 + rvmru_pkg::TABLE_DEPTH + 5), 0);
      drain();
   endtask

   // random reports over pools of varying size
   task automatic test_random_traffic(int count);
      int pool;
      for (int i = 0; i < count; i++) begin
         if (i % 200 == 0) pool = ($urandom_range(0, 2) == 0) ? 20 : $urandom_range(40, 90);
         if ($urandom_range(0, 9) == 0) send_random(30'($urandom), 1);
         else send_random(30'(30'h3FFF0000 + $urandom_range(0, pool)), 1);
         if (i == count / 2) drain();
      end
   endtask

   initial begin
      held = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_field_extremes();
      test_fill_and_evict();
      test_random_traffic(1870);
      drain();
      repeat (200) @(posedge clock);
      $display("%0d reports checked: %0d hits and %0d evictions, with field extremes,",
               reports, hits_seen, evictions_seen);
      $display("a full table and random identity pools under random idle gaps");
      if (errors == 0 && pending_results.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

FILE: files.f
hdl/rvmru_pkg.sv
hdl/recent_vessel_mru_table_core.sv
bench/recent_vessel_mru_table_core_test.sv
